// File: sv/blmc_pkg.sv
// Shared types, mode codes and constants for the button and lamp mode controller.
package blmc_pkg;

   localparam int unsigned TICKS_W = 16;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;

   // Mode numbers as the result beat reports them.
   localparam logic [3:0] MODE_NUM_START       = 4'd0;
   localparam logic [3:0] MODE_NUM_DEFAULT     = 4'd1;
   localparam logic [3:0] MODE_NUM_TIMER_H0    = 4'd2;
   localparam logic [3:0] MODE_NUM_TIMER_L0    = 4'd3;
   localparam logic [3:0] MODE_NUM_TIMER_H1    = 4'd4;
   localparam logic [3:0] MODE_NUM_TIMER_L1    = 4'd5;
   localparam logic [3:0] MODE_NUM_PRE_LAMP    = 4'd6;
   localparam logic [3:0] MODE_NUM_LAMP        = 4'd7;
   localparam logic [3:0] MODE_NUM_PRE_ALWAYS  = 4'd8;
   localparam logic [3:0] MODE_NUM_ALWAYS      = 4'd9;
   localparam logic [3:0] MODE_NUM_POST_ALWAYS = 4'd10;

   typedef enum logic [10:0] {
      MODE_START       = 11'b000_0000_0001,
      MODE_DEFAULT     = 11'b000_0000_0010,
      MODE_TIMER_H0    = 11'b000_0000_0100,
      MODE_TIMER_L0    = 11'b000_0000_1000,
      MODE_TIMER_H1    = 11'b000_0001_0000,
      MODE_TIMER_L1    = 11'b000_0010_0000,
      MODE_PRE_LAMP    = 11'b000_0100_0000,
      MODE_LAMP        = 11'b000_1000_0000,
      MODE_PRE_ALWAYS  = 11'b001_0000_0000,
      MODE_ALWAYS      = 11'b010_0000_0000,
      MODE_POST_ALWAYS = 11'b100_0000_0000
   } mode_type;

   typedef struct packed {
      logic button_level;
      logic voltage_switch;
      logic current_switch;
   } req_type;

   typedef struct packed {
      logic       lamp_on;
      logic       indicator_on;
      logic [3:0] mode_number;
   } rsp_type;

   typedef struct packed {
      mode_type           mode;
      logic [TICKS_W-1:0] press_countdown;
      logic               lamp_flag;
      logic               indicator_flag;
   } state_type;

   function automatic logic [3:0] mode_num(input mode_type m);
      logic [3:0] n;
      unique case (m)
         MODE_DEFAULT:     n = MODE_NUM_DEFAULT;
         MODE_TIMER_H0:    n = MODE_NUM_TIMER_H0;
         MODE_TIMER_L0:    n = MODE_NUM_TIMER_L0;
         MODE_TIMER_H1:    n = MODE_NUM_TIMER_H1;
         MODE_TIMER_L1:    n = MODE_NUM_TIMER_L1;
         MODE_PRE_LAMP:    n = MODE_NUM_PRE_LAMP;
         MODE_LAMP:        n = MODE_NUM_LAMP;
         MODE_PRE_ALWAYS:  n = MODE_NUM_PRE_ALWAYS;
         MODE_ALWAYS:      n = MODE_NUM_ALWAYS;
         MODE_POST_ALWAYS: n = MODE_NUM_POST_ALWAYS;
         default:          n = MODE_NUM_START;
      endcase
      return n;
   endfunction

endpackage

// File: sv/blmc_step.sv
// Next-state logic: one tick of the mode machine plus the press window countdown.
module blmc_step (
   input  blmc_pkg::state_type            state_cur,
   input  blmc_pkg::req_type              req,
   input  logic [blmc_pkg::TICKS_W-1:0]   reload,
   output blmc_pkg::state_type            state_nxt
);
   import blmc_pkg::*;

   logic               btn;
   logic               volt;
   logic               cur;
   logic               cnt_live;
   logic [TICKS_W-1:0] cnt;
   mode_type           m;
   logic               lamp;
   logic               ind;

   assign btn      = req.button_level;
   assign volt     = req.voltage_switch;
   assign cur      = req.current_switch;
   assign cnt_live = (state_cur.press_countdown != '0);

   always_comb begin
      m    = state_cur.mode;
      cnt  = state_cur.press_countdown;
      lamp = state_cur.lamp_flag;
      ind  = state_cur.indicator_flag;
      // later checks in each arm override earlier ones
      unique case (state_cur.mode)
         MODE_DEFAULT: begin
            cnt = reload;
            if (btn && volt) m = MODE_TIMER_H0;
            if (cur && volt) m = MODE_PRE_ALWAYS;
            if (!volt)       m = MODE_START;
         end
         MODE_TIMER_H0: begin
            if (cnt_live && !btn)      m = MODE_TIMER_L0;
            else if (!cnt_live && btn) m = MODE_PRE_LAMP;
            if (!state_cur.indicator_flag && cur) m = MODE_PRE_ALWAYS;
            if (!volt) m = MODE_START;
         end
         MODE_TIMER_L0: begin
            if (cnt_live && btn) m = MODE_TIMER_H1;
            else if (!cnt_live)  m = MODE_DEFAULT;
            if (cur)   m = MODE_PRE_ALWAYS;
            if (!volt) m = MODE_START;
         end
         MODE_TIMER_H1: begin
            if (cnt_live && !btn && !cur) m = MODE_TIMER_L1;
            else if (!cnt_live)           m = MODE_DEFAULT;
            if (cur)   m = MODE_PRE_ALWAYS;
            if (!volt) m = MODE_START;
         end
         MODE_TIMER_L1: begin
            ind = ~state_cur.indicator_flag;
            m   = MODE_DEFAULT;
         end
         MODE_PRE_LAMP: begin
            lamp = ~state_cur.lamp_flag;
            m    = MODE_LAMP;
         end
         MODE_LAMP: begin
            if (!btn && volt) m = MODE_DEFAULT;
            if (cur && volt)  m = MODE_PRE_ALWAYS;
            if (!volt)        m = MODE_START;
         end
         MODE_PRE_ALWAYS: begin
            ind = 1'b1;
            m   = MODE_ALWAYS;
         end
         MODE_ALWAYS: begin
            cnt = reload;
            if (!cur)        m = MODE_POST_ALWAYS;
            if (btn && volt) m = MODE_TIMER_H0;
            if (!volt)       m = MODE_START;
         end
         MODE_POST_ALWAYS: begin
            ind = 1'b0;
            m   = MODE_DEFAULT;
         end
         default: begin
            cnt  = reload;
            lamp = 1'b0;
            ind  = 1'b0;
            m    = MODE_DEFAULT;
         end
      endcase
   end

   // decrement after the state step, saturating at zero
   assign state_nxt.mode            = m;
   assign state_nxt.press_countdown = (cnt != '0) ? cnt - TICKS_W'(1) : cnt;
   assign state_nxt.lamp_flag       = lamp;
   assign state_nxt.indicator_flag  = ind;

endmodule

// File: sv/blmc_out_buf.sv
// Result register with a skid stage so the input side keeps moving under a short stall.
module blmc_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  blmc_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blmc_pkg::rsp_type rsp_data
);
   import blmc_pkg::*;

   logic    main_valid_ff;
   logic    main_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type main_data_ff;
   rsp_type main_data_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_data_in  = push_data;
      end else if (push) begin
         // hold the waiting beat, park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

// File: sv/button_lamp_mode_controller.sv
// Top level of the button and lamp mode controller.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | req_data (button, voltage, current)
//   rsp     | out       | rsp_valid / rsp_stall   | rsp_data (lamp, indicator, mode)
//   csr     | in        | csr_write_enable        | csr_write_data (long press ticks)
//
// One tick per cycle unless req is stalled: each accepted req beat has its rsp beat
// registered in the result buffer. The mode step is one level of next-state logic into
// the state registers. Reset clears the mode to start, the flags and the countdown and
// loads 1000 into the reload register; req_stall is high during reset. A stalled rsp
// beat parks one more result in the skid stage; req_stall rises only when that is full.
module button_lamp_mode_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  blmc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output blmc_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [blmc_pkg::TICKS_W-1:0]    csr_write_data
);
   import blmc_pkg::*;

   logic [TICKS_W-1:0] ticks_ff;
   state_type          state_ff;
   state_type          state_in;
   rsp_type            result;
   logic               buf_full;
   logic               accept;

   assign req_stall = buf_full || reset;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else if (csr_write_enable) begin
         ticks_ff <= csr_write_data;
      end
   end

   blmc_step u_step (
      .state_cur (state_ff),
      .req       (req_data),
      .reload    (ticks_ff),
      .state_nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode            <= MODE_START;
         state_ff.press_countdown <= '0;
         state_ff.lamp_flag       <= 1'b0;
         state_ff.indicator_flag  <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign result.lamp_on      = state_in.lamp_flag;
   assign result.indicator_on = state_in.indicator_flag;
   assign result.mode_number  = mode_num(state_in.mode);

   blmc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/blmc_checker.sv
// Port-level checks for the button and lamp mode controller, bound to the top level.
module blmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input blmc_pkg::rsp_type rsp_data
);
   import blmc_pkg::*;

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("rsp beat changed while stalled");

   // every accepted tick has a result waiting in the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted req beat produced no rsp beat");

   // backpressure on req only comes from a full result buffer
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no rsp beat pending");

   // always-on phases keep the indicator lit
   a_always_ind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.mode_number == MODE_NUM_ALWAYS ||
                     rsp_data.mode_number == MODE_NUM_POST_ALWAYS))
      |-> rsp_data.indicator_on)
      else $error("indicator off in always-on mode");

endmodule

bind button_lamp_mode_controller blmc_checker u_blmc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/button_lamp_mode_controller_test.sv
// Self-checking testbench for the button and lamp mode controller.
module button_lamp_mode_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   import blmc_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [TICKS_W-1:0]  csr_write_data = '0;

   // Copy of the controller state, advanced once per accepted tick.
   logic [3:0]          mode_now = MODE_NUM_START;
   logic [TICKS_W-1:0]  window_count = '0;
   logic [TICKS_W-1:0]  window_reload = TICKS_RESET;
   logic                lamp_now = 1'b0;
   logic                indicator_now = 1'b0;

   req_type             pending_ticks[$];
   rsp_type             predicted_status[$];
   bit                  req_took = 1'b0;
   bit                  steady = 1'b0;
   int unsigned         mismatch_count = 0;
   int unsigned         ticks_queued = 0;
   int unsigned         ticks_checked = 0;
   int unsigned         reloads_written = 0;
   bit [15:0]           modes_seen = '0;

   button_lamp_mode_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // One tick of the mode machine; later checks in a state override earlier ones.
   function automatic rsp_type advance_mode(input req_type tick);
      logic       live;
      logic       btn;
      logic       volt;
      logic       cur;
      logic [3:0] next_mode;
      rsp_type    status;
      live = (window_count != '0);
      btn = tick.button_level;
      volt = tick.voltage_switch;
      cur = tick.current_switch;
      next_mode = mode_now;
      case (mode_now)
         MODE_NUM_DEFAULT: begin
            window_count = window_reload;
            if (btn && volt) next_mode = MODE_NUM_TIMER_H0;
            if (cur && volt) next_mode = MODE_NUM_PRE_ALWAYS;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_TIMER_H0: begin
            if (live && !btn) next_mode = MODE_NUM_TIMER_L0;
            else if (!live && btn) next_mode = MODE_NUM_PRE_LAMP;
            if (!indicator_now && cur) next_mode = MODE_NUM_PRE_ALWAYS;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_TIMER_L0: begin
            if (live && btn) next_mode = MODE_NUM_TIMER_H1;
            else if (!live) next_mode = MODE_NUM_DEFAULT;
            if (cur) next_mode = MODE_NUM_PRE_ALWAYS;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_TIMER_H1: begin
            if (live && !btn && !cur) next_mode = MODE_NUM_TIMER_L1;
            else if (!live) next_mode = MODE_NUM_DEFAULT;
            if (cur) next_mode = MODE_NUM_PRE_ALWAYS;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_TIMER_L1: begin
            indicator_now = ~indicator_now;
            next_mode = MODE_NUM_DEFAULT;
         end
         MODE_NUM_PRE_LAMP: begin
            lamp_now = ~lamp_now;
            next_mode = MODE_NUM_LAMP;
         end
         MODE_NUM_LAMP: begin
            if (!btn && volt) next_mode = MODE_NUM_DEFAULT;
            if (cur && volt) next_mode = MODE_NUM_PRE_ALWAYS;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_PRE_ALWAYS: begin
            indicator_now = 1'b1;
            next_mode = MODE_NUM_ALWAYS;
         end
         MODE_NUM_ALWAYS: begin
            window_count = window_reload;
            if (!cur) next_mode = MODE_NUM_POST_ALWAYS;
            if (btn && volt) next_mode = MODE_NUM_TIMER_H0;
            if (!volt) next_mode = MODE_NUM_START;
         end
         MODE_NUM_POST_ALWAYS: begin
            indicator_now = 1'b0;
            next_mode = MODE_NUM_DEFAULT;
         end
         default: begin
            // start, and any code past the last mode
            window_count = window_reload;
            lamp_now = 1'b0;
            indicator_now = 1'b0;
            next_mode = MODE_NUM_DEFAULT;
         end
      endcase
      mode_now = next_mode;
      // the reload of this tick is already counted down once
      if (window_count != '0) window_count = window_count - TICKS_W'(1);
      status.lamp_on = lamp_now;
      status.indicator_on = indicator_now;
      status.mode_number = mode_now;
      return status;
   endfunction

   task automatic queue_tick(input int unsigned btn, input int unsigned volt,
                             input int unsigned cur);
      req_type tick;
      tick.button_level = btn[0];
      tick.voltage_switch = volt[0];
      tick.current_switch = cur[0];
      pending_ticks.push_back(tick);
      ticks_queued++;
   endtask

   // Drain every queued and outstanding beat, then wait with the block quiet.
   task automatic settle();
      while (pending_ticks.size() != 0 || req_valid || predicted_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reload(input logic [TICKS_W-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      window_reload = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reloads_written++;
   endtask

   // Mostly well-formed button gestures sized to the current reload, some noise.
   task automatic queue_gestures(input int unsigned count);
      int unsigned target;
      int unsigned reload;
      int unsigned hold;
      int unsigned seg;
      int unsigned pick;
      target = ticks_queued + count;
      reload = 32'(window_reload);
      seg = (reload < 8) ? 2 : ((reload / 4 > 8) ? 8 : reload / 4);
      while (ticks_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            hold = (reload > 40) ? $urandom_range(1, 30) : $urandom_range(reload / 2, reload + 3);
            repeat (hold) queue_tick(1, 1, 0);
            repeat ($urandom_range(1, 3)) queue_tick(0, 1, 0);
         end else if (pick < 60) begin
            repeat ($urandom_range(1, seg)) queue_tick(1, 1, 0);
            repeat ($urandom_range(1, seg)) queue_tick(0, 1, 0);
            repeat ($urandom_range(1, seg)) queue_tick(1, 1, 0);
            repeat (2) queue_tick(0, 1, 0);
         end else if (pick < 75) begin
            repeat ($urandom_range(2, 6)) queue_tick($urandom_range(0, 1), 1, 1);
            repeat ($urandom_range(1, 3)) queue_tick($urandom_range(0, 1), 1, 0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 3))
               queue_tick($urandom_range(0, 1), 0, $urandom_range(0, 1));
         end else begin
            repeat ($urandom_range(1, 6))
               queue_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
         end
         repeat ($urandom_range(0, 2)) queue_tick(0, 1, 0);
      end
   endtask

   // Sender: present a new beat once the previous one went through.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
            req_valid <= 1'b1;
            req_data <= pending_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 22);
   end

   task automatic check_field(input string name, input logic [3:0] want,
                              input logic [3:0] got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Check the result beat before predicting from this edge's request beat.
   always @(posedge clock) begin : check_status
      rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_status.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result beat, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = predicted_status.pop_front();
               check_field("lamp_on", 4'(want.lamp_on), 4'(rsp_data.lamp_on));
               check_field("indicator_on", 4'(want.indicator_on), 4'(rsp_data.indicator_on));
               check_field("mode_number", want.mode_number, rsp_data.mode_number);
               modes_seen[rsp_data.mode_number] = 1'b1;
               ticks_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            predicted_status.push_back(advance_mode(req_data));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the gestures at the reset reload value.
      queue_tick(0, 1, 0); queue_tick(1, 1, 0); queue_tick(0, 1, 0); queue_tick(1, 1, 0);
      queue_tick(0, 1, 0); queue_tick(0, 1, 0); queue_tick(1, 1, 1); queue_tick(0, 1, 1);
      queue_tick(1, 1, 0); queue_tick(0, 1, 1); queue_tick(0, 1, 1); queue_tick(0, 1, 0);
      queue_tick(0, 1, 0); queue_tick(0, 1, 0); queue_tick(1, 1, 0); queue_tick(1, 1, 1);
      queue_tick(1, 0, 1); queue_tick(1, 0, 0); queue_tick(1, 0, 0); queue_tick(0, 0, 0);

      // Zero reload: the window is closed from the first press tick.
      write_reload('0);
      queue_tick(0, 1, 0); queue_tick(1, 1, 0); queue_tick(1, 1, 0); queue_tick(0, 0, 0);
      queue_tick(1, 1, 1); queue_tick(0, 1, 0); queue_tick(1, 0, 1); queue_tick(0, 1, 0);

      write_reload(16'd3);
      queue_gestures(200);
      write_reload(16'd1);
      queue_gestures(150);
      write_reload(16'd6);
      steady = 1'b1;
      queue_gestures(200);
      settle();
      steady = 1'b0;
      write_reload(16'hFFFF);
      queue_gestures(50);
      write_reload(16'd12);
      queue_gestures(210);
      write_reload(16'd2);
      queue_gestures(150);
      write_reload('0);
      queue_gestures(60);
      settle();

      $display("Checked %0d ticks across %0d reload writes; %0d of 11 modes reported.",
               ticks_checked, reloads_written, $countones(modes_seen));
      if (mismatch_count == 0) begin
         $display("button_lamp_mode_controller test passed");
      end else begin
         $display("button_lamp_mode_controller test failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d ticks pending and %0d results outstanding.",
               pending_ticks.size(), predicted_status.size());
      $display("button_lamp_mode_controller test failed");
      $finish;
   end

endmodule
